// ----- rtl/sce_pkg.sv -----
// Shared constants, types and helpers for the syllable code expander.
`timescale 1ns / 1ps
`default_nettype none

package sce_pkg;

  // Table geometry
  localparam int ENTRIES    = 15;
  localparam int MAX_CHARS  = 10;
  localparam int TABLE_SIZE = 2 * ENTRIES * MAX_CHARS;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int POS_W      = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  // Result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 2);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [7:0]        char_t;

  // Request types
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // Character constants
  localparam char_t CHAR_SPACE = 8'h20;
  localparam char_t CHAR_NUL   = 8'h00;

  // Table selector, also the emission phase
  typedef enum logic {
    PH_CONS = 1'b0,
    PH_VOW  = 1'b1
  } phase_e;

  typedef struct packed {
    char_t out_char;
    logic  last_char;
  } out_item_t;

  // Start address of one entry in the shared table memory
  function automatic addr_t tbl_base(logic sel, logic [3:0] idx);
    int flat;
    flat = (int'(sel) * ENTRIES + int'(idx)) * MAX_CHARS;
    return addr_t'(flat);
  endfunction

  // Nibble selects an entry when it is 1..ENTRIES
  function automatic logic nib_ok(logic [3:0] nib);
    return (nib != 4'd0) && (nib <= 4'(ENTRIES));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sce_if.sv -----
// Request and result channel interfaces of the syllable code expander.
`timescale 1ns / 1ps
`default_nettype none

interface sce_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic       table_sel;
  logic [3:0] entry_index;
  logic [3:0] char_pos;
  logic [7:0] char_value;
  logic [7:0] code_byte;

  modport source (output valid, req_type, table_sel, entry_index, char_pos, char_value,
                  code_byte, input ready);
  modport sink (input valid, req_type, table_sel, entry_index, char_pos, char_value,
                code_byte, output ready);
endinterface

interface sce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink (input valid, out_char, last_char, output ready);
endinterface

`default_nettype wire

// ----- rtl/syllable_code_expander_unit.sv -----
// Syllable code expander: table memory, read sequencer and result queue.
//
// Usage
//   in_i carries requests. A write request (req_type 0) stores one character
//   of one consonant or vowel entry in the table memory; it gives no result.
//   A decode request (req_type 1) expands one code byte into characters on
//   out_o, one result per character, last_char set on the final one. A code
//   byte of zero gives one space.
//   A write request is stored in the table memory when it is accepted. A
//   decode request makes one table read per character plus one per entry
//   that ends on a zero beyond its first position. The next request is
//   taken only once the decode has finished. Read data passes through a
//   hold register into the result queue. The memory port sets the rate:
//   one table read and one character per cycle while the queue has room.
//   in_i.ready is high whenever no decode is in progress; the next request
//   is taken while earlier characters still sit in the four-entry result
//   queue.
//   When out_o stalls, the queue fills and the sequencer holds off further
//   table reads until there is room; nothing is dropped.
//   Reset clears the sequencer and the queue. The table memory is not
//   cleared; each entry must be fully written before it is decoded.
`timescale 1ns / 1ps
`default_nettype none

module syllable_code_expander_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  sce_in_if.sink     in_i,
  sce_out_if.source  out_o
);
  import sce_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  localparam pos_t LAST_POS = pos_t'(MAX_CHARS - 1);

  // Control state
  state_e     state_q, state_d;
  logic       rd_v_q;
  logic       cur_live_q, cur_live_d;
  logic       hold_v_q, hold_v_d;
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fifo_cnt_q, fifo_cnt_d;

  // Payload state
  phase_e     cur_ph_q, cur_ph_d;
  pos_t       cur_pos_q, cur_pos_d;
  phase_e     rd_ph_q;
  pos_t       rd_pos_q;
  char_t      rd_data_q;
  char_t      hold_q, hold_d;
  addr_t      cons_base_q, cons_base_d;
  addr_t      vow_base_q, vow_base_d;
  logic       vow_ok_q, vow_ok_d;
  out_item_t  fifo_q [FIFO_DEPTH];

  // Table memory
  char_t      mem_q [TABLE_SIZE];

  logic       in_acc, acc_wr, acc_dec;
  logic       mem_we;
  addr_t      wr_addr, rd_addr;
  logic       run, term, issue, fin, fin_push, ret_push, push, pop;
  phase_e     eff_ph, nxt_ph;
  pos_t       eff_pos, nxt_pos;
  logic       eff_live, nxt_live;
  logic [3:0] hi_nib, lo_nib;
  logic       hi_ok, lo_ok;
  out_item_t  push_item;

  // Request handshake
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign acc_wr     = in_acc && (in_i.req_type == REQ_WRITE);
  assign acc_dec    = in_acc && (in_i.req_type == REQ_DECODE);

  // Table write path
  assign mem_we  = acc_wr && (in_i.entry_index < 4'(ENTRIES)) &&
                   ({1'b0, in_i.char_pos} < 5'(MAX_CHARS));
  assign wr_addr = tbl_base(in_i.table_sel, in_i.entry_index) + addr_t'(in_i.char_pos);

  // Code byte decode
  assign hi_nib = in_i.code_byte[7:4];
  assign lo_nib = in_i.code_byte[3:0];
  assign hi_ok  = nib_ok(hi_nib);
  assign lo_ok  = nib_ok(lo_nib);

  assign run = (state_q == ST_RUN);

  // A zero beyond the first position ends the entry being read
  assign term = rd_v_q && (rd_pos_q != '0) && (rd_data_q == CHAR_NUL);

  // Read cursor: skip the rest of an entry on its terminator, then advance
  always_comb begin
    eff_ph   = cur_ph_q;
    eff_pos  = cur_pos_q;
    eff_live = cur_live_q;
    if (term) begin
      eff_ph   = PH_VOW;
      eff_pos  = '0;
      eff_live = (rd_ph_q == PH_CONS) && vow_ok_q;
    end
    nxt_ph   = eff_ph;
    nxt_pos  = eff_pos + pos_t'(1);
    nxt_live = eff_live;
    if (eff_pos == LAST_POS) begin
      nxt_ph   = PH_VOW;
      nxt_pos  = '0;
      nxt_live = (eff_ph == PH_CONS) && vow_ok_q;
    end
  end

  // Issue a read only when the queue can take the character it displaces
  assign issue   = run && eff_live &&
                   ((fifo_cnt_q + CNT_W'(rd_v_q)) < CNT_W'(FIFO_DEPTH));
  assign rd_addr = ((eff_ph == PH_VOW) ? vow_base_q : cons_base_q) + addr_t'(eff_pos);

  // Finish: nothing left to read; the held character is the last one
  assign fin      = run && !eff_live && !rd_v_q;
  assign fin_push = fin && hold_v_q && (fifo_cnt_q < CNT_W'(FIFO_DEPTH));

  // Returned character displaces the held one, which is then not last
  assign ret_push = rd_v_q && !term && hold_v_q;

  assign push      = ret_push || fin_push;
  assign push_item = '{out_char: hold_q, last_char: fin_push};
  assign pop       = out_o.valid && out_o.ready;

  // Next state of sequencer and hold register
  always_comb begin
    state_d     = state_q;
    cur_ph_d    = cur_ph_q;
    cur_pos_d   = cur_pos_q;
    cur_live_d  = cur_live_q;
    hold_d      = hold_q;
    hold_v_d    = hold_v_q;
    cons_base_d = cons_base_q;
    vow_base_d  = vow_base_q;
    vow_ok_d    = vow_ok_q;

    unique case (state_q)
      ST_IDLE: begin
        if (acc_dec) begin
          state_d     = ST_RUN;
          cons_base_d = tbl_base(PH_CONS, hi_nib - 4'd1);
          vow_base_d  = tbl_base(PH_VOW, lo_nib - 4'd1);
          vow_ok_d    = lo_ok;
          cur_pos_d   = '0;
          if (in_i.code_byte == 8'h00) begin
            hold_d     = CHAR_SPACE;
            hold_v_d   = 1'b1;
            cur_live_d = 1'b0;
            cur_ph_d   = PH_CONS;
          end else if (hi_ok) begin
            cur_ph_d   = PH_CONS;
            cur_live_d = 1'b1;
          end else begin
            cur_ph_d   = PH_VOW;
            cur_live_d = lo_ok;
          end
        end
      end
      ST_RUN: begin
        if (issue) begin
          cur_ph_d   = nxt_ph;
          cur_pos_d  = nxt_pos;
          cur_live_d = nxt_live;
        end else begin
          cur_ph_d   = eff_ph;
          cur_pos_d  = eff_pos;
          cur_live_d = eff_live;
        end
        if (rd_v_q && !term) begin
          hold_d   = rd_data_q;
          hold_v_d = 1'b1;
        end else if (fin_push) begin
          hold_v_d = 1'b0;
        end
        if (fin && (!hold_v_q || fin_push)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign fifo_cnt_d = fifo_cnt_q + CNT_W'(push) - CNT_W'(pop);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_v_q     <= 1'b0;
      cur_live_q <= 1'b0;
      hold_v_q   <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      rd_v_q     <= issue;
      cur_live_q <= cur_live_d;
      hold_v_q   <= hold_v_d;
      fifo_cnt_q <= fifo_cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_ph_q    <= cur_ph_d;
    cur_pos_q   <= cur_pos_d;
    hold_q      <= hold_d;
    cons_base_q <= cons_base_d;
    vow_base_q  <= vow_base_d;
    vow_ok_q    <= vow_ok_d;
    if (issue) begin
      rd_ph_q  <= eff_ph;
      rd_pos_q <= eff_pos;
    end
    if (push) begin
      fifo_q[wr_ptr_q] <= push_item;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= in_i.char_value;
    end
    if (issue) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Result channel
  assign out_o.valid     = (fifo_cnt_q != '0);
  assign out_o.out_char  = fifo_q[rd_ptr_q].out_char;
  assign out_o.last_char = fifo_q[rd_ptr_q].last_char;

  // Checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt_q < CNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

  a_read_while_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> (state_q == ST_RUN))
    else $error("table read returned outside a decode");

  a_last_ends_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_push |=> (state_q == ST_IDLE) && !hold_v_q)
    else $error("decode did not end after its last character");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!rd_v_q && !hold_v_q))
    else $error("request taken with a decode still in flight");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the syllable code expander unit.
`timescale 1ns / 1ps

module tb_top;
  import sce_pkg::*;

  // Tracks the table contents and the characters each decode must produce
  class expansion_scoreboard;
    char_t      table_copy [2*ENTRIES*MAX_CHARS];
    out_item_t  expected_chars [$];
    int         mismatches = 0;
    int         results_seen = 0;

    // Append the characters of one entry, nibble n picks entry n-1
    function void add_entry_chars(ref out_item_t q[$], input phase_e sel,
                                  input logic [3:0] nib);
      int base;
      int len;
      if (nib == 4'd0 || int'(nib) > ENTRIES) return;
      base = (int'(sel) * ENTRIES + int'(nib) - 1) * MAX_CHARS;
      len = 1;
      while (len < MAX_CHARS && table_copy[base + len] != CHAR_NUL) len++;
      for (int p = 0; p < len; p++)
        q.push_back('{out_char: table_copy[base + p], last_char: 1'b0});
    endfunction

    // Accepted request: update the table copy or queue the expansion
    function void note_request(input logic req, input logic sel, input logic [3:0] idx,
                               input logic [3:0] pos, input char_t val, input char_t code);
      out_item_t burst [$];
      if (req == REQ_WRITE) begin
        if (int'(idx) < ENTRIES && int'(pos) < MAX_CHARS)
          table_copy[(int'(sel) * ENTRIES + int'(idx)) * MAX_CHARS + int'(pos)] = val;
        return;
      end
      if (code == 8'h00) begin
        burst.push_back('{out_char: CHAR_SPACE, last_char: 1'b1});
      end else begin
        add_entry_chars(burst, PH_CONS, code[7:4]);
        add_entry_chars(burst, PH_VOW, code[3:0]);
        if (burst.size() > 0) burst[burst.size() - 1].last_char = 1'b1;
      end
      foreach (burst[i]) expected_chars.push_back(burst[i]);
    endfunction

    // Accepted result: compare with the oldest expected character
    function void check_char(input char_t got_char, input logic got_last);
      out_item_t want;
      if (expected_chars.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected char %02h last %0b", $realtime, got_char, got_last);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      results_seen++;
      if (got_char !== want.out_char || got_last !== want.last_char) begin
        if (mismatches < 10)
          $display("%0t: char exp %02h got %02h, last exp %0b got %0b", $realtime,
                   want.out_char, got_char, want.last_char, got_last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  sce_in_if  in_bus ();
  sce_out_if out_bus ();

  syllable_code_expander_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  expansion_scoreboard sb = new();

  // Positions written so far per entry; an entry is decoded only when full
  bit [MAX_CHARS-1:0] filled_pos [2][ENTRIES];
  bit settle_phase = 1'b0;

  // Directed consonant content covering character extremes
  char_t ramp [MAX_CHARS] = '{8'hFF, 8'h01, 8'h80, 8'h7F, 8'hAA,
                              8'h55, 8'hFE, 8'h02, 8'h40, 8'h20};

  always #10 clk_i = ~clk_i;

  // Offer one request and hold it until the handshake completes
  task automatic send_req(input logic req, input logic sel, input logic [3:0] idx,
                          input logic [3:0] pos, input char_t val, input char_t code);
    if (!settle_phase && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.req_type    <= req;
    in_bus.table_sel   <= sel;
    in_bus.entry_index <= idx;
    in_bus.char_pos    <= pos;
    in_bus.char_value  <= val;
    in_bus.code_byte   <= code;
    @(posedge clk_i);
    while (in_bus.ready !== 1'b1) @(posedge clk_i);
    sb.note_request(req, sel, idx, pos, val, code);
  endtask

  // Table write; the code byte is unused and random
  task automatic send_write(input logic sel, input logic [3:0] idx, input logic [3:0] pos,
                            input char_t val);
    if (int'(idx) < ENTRIES && int'(pos) < MAX_CHARS) filled_pos[sel][idx][pos] = 1'b1;
    send_req(REQ_WRITE, sel, idx, pos, val, char_t'($urandom));
  endtask

  // Decode; the write fields are unused and random
  task automatic send_decode(input char_t code);
    send_req(REQ_DECODE, 1'($urandom), 4'($urandom), 4'($urandom), char_t'($urandom), code);
  endtask

  // Write a whole entry: len nonzero chars, a zero when len < MAX_CHARS, random tail
  task automatic fill_entry(input logic sel, input logic [3:0] idx, input int len);
    char_t v;
    for (int p = 0; p < MAX_CHARS; p++) begin
      if (p < len) v = char_t'($urandom_range(1, 255));
      else if (p == len) v = CHAR_NUL;
      else v = char_t'($urandom);
      send_write(sel, idx, 4'(p), v);
    end
  endtask

  // Drop valid and hold off until every expected character has arrived
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_chars.size() != 0) @(posedge clk_i);
  endtask

  // Nibble for a decode: a fully written entry, or sometimes none
  function automatic logic [3:0] pick_nibble(input logic sel);
    int full_q [$];
    for (int e = 0; e < ENTRIES; e++)
      if (&filled_pos[sel][e]) full_q.push_back(e);
    if (full_q.size() == 0 || $urandom_range(0, 7) == 0) return 4'd0;
    return 4'(full_q[$urandom_range(0, full_q.size() - 1)] + 1);
  endfunction

  // Next entry to fill: one not yet fully written while any remain
  function automatic int pick_fill_target();
    int open_q [$];
    for (int k = 0; k < 2 * ENTRIES; k++)
      if (!(&filled_pos[k / ENTRIES][k % ENTRIES])) open_q.push_back(k);
    if (open_q.size() == 0) return $urandom_range(0, 2 * ENTRIES - 1);
    return open_q[$urandom_range(0, open_q.size() - 1)];
  endfunction

  // Result side: check accepted characters, stall in random bursts
  initial begin : result_sink
    int hold_cycles;
    bit long_hold_done;
    hold_cycles = 0;
    long_hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        sb.check_char(out_bus.out_char, out_bus.last_char);
      if (hold_cycles == 0 && !settle_phase) begin
        // one long hold so the queue fills and the input stalls
        if (!long_hold_done && sb.results_seen >= 60) begin
          hold_cycles = 120;
          long_hold_done = 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
          hold_cycles = $urandom_range(1, 3);
        end
      end
      if (hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Request side: reset, directed requests, random requests, drain
  initial begin : stimulus
    int random_items;
    int pick;
    int target;
    bit drained_once;
    random_items = 0;
    drained_once = 1'b0;
    rst_ni             <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.req_type    <= REQ_WRITE;
    in_bus.table_sel   <= 1'b0;
    in_bus.entry_index <= 4'd0;
    in_bus.char_pos    <= 4'd0;
    in_bus.char_value  <= 8'h00;
    in_bus.code_byte   <= 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full-length consonant, zero-first vowel in the last entry
    for (int p = 0; p < MAX_CHARS; p++) send_write(PH_CONS, 4'd0, 4'(p), ramp[p]);
    for (int p = 0; p < MAX_CHARS; p++)
      send_write(PH_VOW, 4'(ENTRIES - 1), 4'(p), (p < 2) ? CHAR_NUL : ramp[p]);
    // writes outside the table are dropped
    send_write(PH_CONS, 4'(ENTRIES), 4'd0, 8'h33);
    send_write(PH_VOW, 4'd0, 4'd15, 8'h44);
    send_write(PH_CONS, 4'd0, 4'(MAX_CHARS), 8'h66);
    // space, both entries, consonant only, vowel only
    send_decode(8'h00);
    send_decode({4'd1, 4'(ENTRIES)});
    send_decode({4'd1, 4'd0});
    send_decode({4'd0, 4'(ENTRIES)});

    // Random: entry fills followed by decodes, with stray writes
    while (random_items < 380) begin
      if (random_items >= 320) settle_phase = 1'b1;
      if (!drained_once && random_items >= 190) begin
        drained_once = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        target = pick_fill_target();
        fill_entry(1'(target / ENTRIES), 4'(target % ENTRIES), $urandom_range(0, MAX_CHARS));
        random_items += MAX_CHARS;
      end else if (pick == 3) begin
        if ($urandom_range(0, 1) == 0) begin
          send_write(1'($urandom), 4'($urandom_range(0, ENTRIES - 1)),
                     4'($urandom_range(0, MAX_CHARS - 1)), char_t'($urandom));
          random_items++;
        end else if ($urandom_range(0, 1) == 0) begin
          send_write(1'($urandom), 4'(ENTRIES), 4'($urandom), char_t'($urandom));
        end else begin
          send_write(1'($urandom), 4'($urandom), 4'($urandom_range(MAX_CHARS, 15)),
                     char_t'($urandom));
        end
      end else begin
        send_decode({pick_nibble(PH_CONS), pick_nibble(PH_VOW)});
        random_items++;
      end
    end

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
      $display("[syllable_code_expander_unit] OK");
    end else begin
      $display("[syllable_code_expander_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #4ms;
    $display("[syllable_code_expander_unit] ERROR");
    $finish;
  end

endmodule
